// File: hdl/ldpf_pkg.sv
// Shared types, constants and helper functions for the LED dimmer patch and fade control unit.
package ldpf_pkg;

    localparam int TICK_W = 16;
    localparam int THR_W = TICK_W + 1;
    localparam int HOLD_W = 11;
    localparam int STEP_W = 8;
    localparam int CHAN_W = 8;
    localparam int PATCH_W = 3;
    localparam int LEVELS = 4;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [2:0] {
        REG_HOLD_SEC_1  = 3'd0,
        REG_HOLD_SEC_2  = 3'd1,
        REG_HOLD_SEC_3  = 3'd2,
        REG_HOLD_SEC_4  = 3'd3,
        REG_FADE_STEP_1 = 3'd4,
        REG_FADE_STEP_2 = 3'd5,
        REG_FADE_STEP_3 = 3'd6,
        REG_FADE_STEP_4 = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [LEVELS-1:0][THR_W-1:0]  hold_thr;
        logic [LEVELS-1:0][STEP_W-1:0] fade_step;
    } cfg_t;

    typedef struct packed {
        logic              fading;
        logic [CHAN_W-1:0] level;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } result_t;

    // Patch colours packed as {blue, green, red}.
    function automatic logic [3*CHAN_W-1:0] patch_colour(input logic [PATCH_W-1:0] idx);
        logic [3*CHAN_W-1:0] c;
        case (idx)
            3'd0:    c = {8'd255, 8'd255, 8'd255};
            3'd1:    c = {8'd33,  8'd74,  8'd255};
            3'd2:    c = {8'd255, 8'd52,  8'd255};
            3'd3:    c = {8'd44,  8'd255, 8'd232};
            3'd4:    c = {8'd255, 8'd255, 8'd106};
            default: c = '0;
        endcase
        return c;
    endfunction

    // Moves one step from the falling channel to the rising one; returns {dst, src}.
    // When the falling channel would wrap, or the step is zero, it stops at zero and the rising one goes full.
    function automatic logic [2*CHAN_W-1:0] wheel_move(input logic [CHAN_W-1:0] src,
                                                        input logic [CHAN_W-1:0] dst,
                                                        input logic [STEP_W-1:0] step);
        logic [CHAN_W-1:0] t;
        t = src - step;
        if (t >= src)
        begin
            return {8'd255, 8'd0};
        end
        return {dst + step, t};
    endfunction

endpackage

// File: hdl/ldpf_cfg.sv
// APB register block holding hold times, fade steps and the derived tick thresholds.
module ldpf_cfg #(
    parameter int TICKS_PER_SECOND = 61
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ldpf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ldpf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ldpf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output ldpf_pkg::cfg_t                     cfg
);
    import ldpf_pkg::*;

    localparam int PROD_W = THR_W + $clog2(TICKS_PER_SECOND + 1);

    // A hold time in seconds becomes a tick threshold; anything past the counter range saturates.
    function automatic logic [THR_W-1:0] ticks_of(input logic [HOLD_W-1:0] secs);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(secs) * PROD_W'(TICKS_PER_SECOND);
        if (prod[PROD_W-1:TICK_W] != '0)
        begin
            return {1'b1, {TICK_W{1'b0}}};
        end
        return {1'b0, prod[TICK_W-1:0]};
    endfunction

    logic [LEVELS-1:0][HOLD_W-1:0] hold_sec_reg, hold_sec_next;
    logic [LEVELS-1:0][THR_W-1:0]  hold_thr_reg, hold_thr_next;
    logic [LEVELS-1:0][STEP_W-1:0] fade_step_reg, fade_step_next;
    reg_idx_t                      reg_idx;
    logic                          wr_en;

    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite & pready;
    assign pready  = 1'b1;

    always_comb
    begin
        hold_sec_next  = hold_sec_reg;
        hold_thr_next  = hold_thr_reg;
        fade_step_next = fade_step_reg;
        if (wr_en)
        begin
            unique case (reg_idx) inside
                REG_HOLD_SEC_1, REG_HOLD_SEC_2, REG_HOLD_SEC_3, REG_HOLD_SEC_4:
                begin
                    hold_sec_next[reg_idx[1:0]] = pwdata[HOLD_W-1:0];
                    hold_thr_next[reg_idx[1:0]] = ticks_of(pwdata[HOLD_W-1:0]);
                end
                REG_FADE_STEP_1, REG_FADE_STEP_2, REG_FADE_STEP_3, REG_FADE_STEP_4:
                begin
                    fade_step_next[reg_idx[1:0]] = pwdata[STEP_W-1:0];
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx) inside
            REG_HOLD_SEC_1, REG_HOLD_SEC_2, REG_HOLD_SEC_3, REG_HOLD_SEC_4:
            begin
                prdata = APB_DATA_W'(hold_sec_reg[reg_idx[1:0]]);
            end
            REG_FADE_STEP_1, REG_FADE_STEP_2, REG_FADE_STEP_3, REG_FADE_STEP_4:
            begin
                prdata = APB_DATA_W'(fade_step_reg[reg_idx[1:0]]);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_sec_reg  <= {11'd4, 11'd3, 11'd2, 11'd1};
            hold_thr_reg  <= {ticks_of(11'd4), ticks_of(11'd3), ticks_of(11'd2), ticks_of(11'd1)};
            fade_step_reg <= {8'd8, 8'd4, 8'd2, 8'd1};
        end
        else
        begin
            hold_sec_reg  <= hold_sec_next;
            hold_thr_reg  <= hold_thr_next;
            fade_step_reg <= fade_step_next;
        end
    end

    assign cfg.hold_thr  = hold_thr_reg;
    assign cfg.fade_step = fade_step_reg;

endmodule

// File: hdl/ldpf_core.sv
// Control pass: tick counter, button handling, colour wheel, patch select and result register.
module ldpf_core #(
    parameter int POT_FLOOR   = 0,
    parameter int PATCH_COUNT = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic                          button_down,
    input  logic [ldpf_pkg::CHAN_W-1:0]   pot_level,
    input  logic                          tick,
    input  ldpf_pkg::cfg_t                cfg,
    output ldpf_pkg::result_t             result
);
    import ldpf_pkg::*;

    logic [TICK_W-1:0]              tick_count_reg, tick_count_next;
    logic                           last_button_reg;
    logic                           fade_on_reg, fade_on_next;
    logic [STEP_W-1:0]              current_step_reg, current_step_next;
    logic [STEP_W-1:0]              last_step_reg, last_step_next;
    logic [2:0][CHAN_W-1:0]         wheel_reg, wheel_next;
    logic                           red_to_green_reg, red_to_green_next;
    logic [PATCH_W-1:0]             patch_index_reg, patch_index_next;
    result_t                        result_reg, result_next;

    logic [TICK_W-1:0]              tc_inc;
    logic [LEVELS-1:0]              reached;
    logic [2:0][CHAN_W-1:0]         wheel_base;
    logic [2*CHAN_W-1:0]            moved;
    logic [3*CHAN_W-1:0]            patch_rgb;

    assign tc_inc = tick ? tick_count_reg + TICK_W'(1) : tick_count_reg;

    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            reached[i] = {1'b0, tc_inc} >= cfg.hold_thr[i];
        end
    end

    always_comb
    begin
        tick_count_next   = tc_inc;
        fade_on_next      = fade_on_reg;
        current_step_next = current_step_reg;
        patch_index_next  = patch_index_reg;
        if (!last_button_reg && button_down)
        begin
            tick_count_next = '0;
        end
        else if (button_down)
        begin
            fade_on_next = 1'b1;
            if (reached[3])
            begin
                current_step_next = cfg.fade_step[3];
            end
            else if (reached[2])
            begin
                current_step_next = cfg.fade_step[2];
            end
            else if (reached[1])
            begin
                current_step_next = cfg.fade_step[1];
            end
            else if (reached[0])
            begin
                current_step_next = cfg.fade_step[0];
            end
            else
            begin
                fade_on_next = 1'b0;
            end
        end
        else if (last_button_reg && !reached[0])
        begin
            fade_on_next = 1'b0;
            if (patch_index_reg >= PATCH_W'(PATCH_COUNT - 1))
            begin
                patch_index_next = '0;
            end
            else
            begin
                patch_index_next = patch_index_reg + PATCH_W'(1);
            end
        end
    end

    always_comb
    begin
        wheel_base = wheel_reg;
        if (last_step_reg != current_step_next)
        begin
            wheel_base[0] = 8'd255;
            wheel_base[1] = 8'd0;
            wheel_base[2] = 8'd0;
        end
        wheel_next        = wheel_base;
        red_to_green_next = red_to_green_reg;
        moved             = '0;
        if (red_to_green_reg)
        begin
            moved         = wheel_move(wheel_base[0], wheel_base[1], current_step_next);
            wheel_next[0] = moved[CHAN_W-1:0];
            wheel_next[1] = moved[2*CHAN_W-1:CHAN_W];
            red_to_green_next = wheel_next[0] != '0;
        end
        else if (wheel_base[1] != '0)
        begin
            moved         = wheel_move(wheel_base[1], wheel_base[2], current_step_next);
            wheel_next[1] = moved[CHAN_W-1:0];
            wheel_next[2] = moved[2*CHAN_W-1:CHAN_W];
        end
        else
        begin
            moved         = wheel_move(wheel_base[2], wheel_base[0], current_step_next);
            wheel_next[2] = moved[CHAN_W-1:0];
            wheel_next[0] = moved[2*CHAN_W-1:CHAN_W];
            red_to_green_next = wheel_next[0] == 8'd255;
        end
        last_step_next = current_step_next;
    end

    assign patch_rgb = patch_colour(patch_index_next);

    always_comb
    begin
        result_next.fading = fade_on_next;
        result_next.level  = (pot_level < CHAN_W'(POT_FLOOR)) ? '0 : pot_level;
        if (fade_on_next)
        begin
            result_next.red   = wheel_next[0];
            result_next.green = wheel_next[1];
            result_next.blue  = wheel_next[2];
        end
        else
        begin
            result_next.red   = patch_rgb[CHAN_W-1:0];
            result_next.green = patch_rgb[2*CHAN_W-1:CHAN_W];
            result_next.blue  = patch_rgb[3*CHAN_W-1:2*CHAN_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg   <= '0;
            last_button_reg  <= 1'b0;
            fade_on_reg      <= 1'b0;
            current_step_reg <= '0;
            last_step_reg    <= '0;
            wheel_reg        <= '0;
            red_to_green_reg <= 1'b1;
            patch_index_reg  <= '0;
        end
        else if (fire)
        begin
            tick_count_reg   <= tick_count_next;
            last_button_reg  <= button_down;
            fade_on_reg      <= fade_on_next;
            current_step_reg <= current_step_next;
            if (fade_on_next)
            begin
                last_step_reg    <= last_step_next;
                wheel_reg        <= wheel_next;
                red_to_green_reg <= red_to_green_next;
            end
            patch_index_reg  <= patch_index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// File: hdl/led_dimmer_patch_and_fade_control_unit.sv
// Top level of the LED dimmer patch and fade control unit with stream and APB ports.
// Each input beat is one control pass: it is taken into an input register, evaluated against
// the tick counter, button and colour-wheel state once the output register can take its result,
// and its result beat lands in the output register. One beat can be accepted every cycle while
// downstream backpressure does not stall the output; that is the only limit on rate. Hold times are
// written in seconds and turned into tick thresholds when written. Configuration should only
// be written while no beat is in flight.
module led_dimmer_patch_and_fade_control_unit #(
    parameter int TICKS_PER_SECOND = 61,
    parameter int POT_FLOOR        = 0,
    parameter int PATCH_COUNT      = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // button_down [0], pot_level [8:1], tick [9], zero [15:10]
    input  logic [ldpf_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // red [7:0], green [15:8], blue [23:16], level [31:24], fading [32], zero [39:33]
    output logic [ldpf_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ldpf_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [ldpf_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [ldpf_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import ldpf_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              button_reg;
    logic [CHAN_W-1:0] pot_reg;
    logic              tick_reg;
    logic              s_fire;
    logic              advance;
    cfg_t              cfg;
    result_t           result;

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign s_fire   = s_tvalid & s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            button_reg <= s_tdata[0];
            pot_reg    <= s_tdata[CHAN_W:1];
            tick_reg   <= s_tdata[CHAN_W+1];
        end
    end

    ldpf_cfg #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ldpf_core #(
        .POT_FLOOR   (POT_FLOOR),
        .PATCH_COUNT (PATCH_COUNT)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .button_down (button_reg),
        .pot_level   (pot_reg),
        .tick        (tick_reg),
        .cfg         (cfg),
        .result      (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(result);

endmodule

// File: bench/ldpf_checker.sv
// Checker for the LED dimmer control unit: predicts each strip output beat and compares it.
module ldpf_checker #(
    parameter int TICKS_PER_SECOND = 61,
    parameter int POT_FLOOR        = 0,
    parameter int PATCH_COUNT      = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // button_down [0], pot_level [8:1], tick [9], zero [15:10]
    input  logic [ldpf_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // red [7:0], green [15:8], blue [23:16], level [31:24], fading [32], zero [39:33]
    input  logic [ldpf_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [ldpf_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ldpf_pkg::APB_DATA_W-1:0]  pwdata,
    output int                               failures,
    output int                               pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ldpf_pkg::*;

    logic [TICK_W-1:0]  ticks;
    logic               btn_prev;
    logic               fade_active;
    logic [STEP_W-1:0]  step_now;
    logic [STEP_W-1:0]  step_prev;
    logic [CHAN_W-1:0]  wheel [3];
    logic               toward_green;
    logic [PATCH_W-1:0] patch_sel;
    logic [HOLD_W-1:0]  hold_secs [LEVELS];
    logic [STEP_W-1:0]  steps [LEVELS];
    result_t            strip_due [$];

    function automatic logic [3*CHAN_W-1:0] patch_rgb(input logic [PATCH_W-1:0] idx);
        case (idx)
            3'd0:    return {8'd255, 8'd255, 8'd255};
            3'd1:    return {8'd255, 8'd74,  8'd33};
            3'd2:    return {8'd255, 8'd52,  8'd255};
            3'd3:    return {8'd232, 8'd255, 8'd44};
            3'd4:    return {8'd106, 8'd255, 8'd255};
            default: return '0;
        endcase
    endfunction

    // A falling channel that would wrap below zero, or is poured with a zero amount, empties and fills the rising one.
    function automatic void pour(input int from, input int into, input logic [STEP_W-1:0] amt);
        logic [CHAN_W-1:0] rest;
        rest = wheel[from] - amt;
        if (rest >= wheel[from])
        begin
            wheel[from] = '0;
            wheel[into] = 8'd255;
        end
        else
        begin
            wheel[from] = rest;
            wheel[into] = wheel[into] + amt;
        end
    endfunction

    function automatic void turn_wheel(input logic [STEP_W-1:0] amt);
        if (step_prev != amt)
        begin
            wheel[0] = 8'd255;
            wheel[1] = '0;
            wheel[2] = '0;
        end
        if (toward_green)
        begin
            pour(0, 1, amt);
            toward_green = (wheel[0] != '0);
        end
        else if (wheel[1] != '0)
        begin
            pour(1, 2, amt);
        end
        else
        begin
            pour(2, 0, amt);
            toward_green = (wheel[0] == 8'd255);
        end
        step_prev = amt;
    endfunction

    function automatic result_t strip_for_pass(input logic btn, input logic [7:0] pot,
                                               input logic tk);
        result_t             r;
        int unsigned         secs;
        logic [3*CHAN_W-1:0] rgb;
        if (tk)
        begin
            ticks = ticks + 1'b1;
        end
        secs = ticks / TICKS_PER_SECOND;
        if (!btn_prev && btn)
        begin
            ticks = '0;
        end
        else if (btn)
        begin
            fade_active = 1'b1;
            if (secs >= hold_secs[3])
                step_now = steps[3];
            else if (secs >= hold_secs[2])
                step_now = steps[2];
            else if (secs >= hold_secs[1])
                step_now = steps[1];
            else if (secs >= hold_secs[0])
                step_now = steps[0];
            else
                fade_active = 1'b0;
        end
        else if (btn_prev && secs < hold_secs[0])
        begin
            fade_active = 1'b0;
            patch_sel = PATCH_W'((int'(patch_sel) + 1) % PATCH_COUNT);
        end
        btn_prev = btn;
        if (fade_active)
        begin
            turn_wheel(step_now);
            rgb = {wheel[0], wheel[1], wheel[2]};
        end
        else
        begin
            rgb = patch_rgb(patch_sel);
        end
        r.red = rgb[23:16];
        r.green = rgb[15:8];
        r.blue = rgb[7:0];
        r.level = (int'(pot) < POT_FLOOR) ? '0 : pot;
        r.fading = fade_active;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            failures++;
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            ticks = '0;
            btn_prev = 1'b0;
            fade_active = 1'b0;
            step_now = '0;
            step_prev = '0;
            wheel[0] = '0;
            wheel[1] = '0;
            wheel[2] = '0;
            toward_green = 1'b1;
            patch_sel = '0;
            hold_secs[0] = 11'd1;
            hold_secs[1] = 11'd2;
            hold_secs[2] = 11'd3;
            hold_secs[3] = 11'd4;
            steps[0] = 8'd1;
            steps[1] = 8'd2;
            steps[2] = 8'd4;
            steps[3] = 8'd8;
            strip_due.delete();
            failures = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_HOLD_SEC_1:  hold_secs[0] = pwdata[HOLD_W-1:0];
                    REG_HOLD_SEC_2:  hold_secs[1] = pwdata[HOLD_W-1:0];
                    REG_HOLD_SEC_3:  hold_secs[2] = pwdata[HOLD_W-1:0];
                    REG_HOLD_SEC_4:  hold_secs[3] = pwdata[HOLD_W-1:0];
                    REG_FADE_STEP_1: steps[0] = pwdata[STEP_W-1:0];
                    REG_FADE_STEP_2: steps[1] = pwdata[STEP_W-1:0];
                    REG_FADE_STEP_3: steps[2] = pwdata[STEP_W-1:0];
                    REG_FADE_STEP_4: steps[3] = pwdata[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (strip_due.size() == 0)
                begin
                    failures++;
                    $error("output beat %h with no pass outstanding", m_tdata);
                end
                else
                begin
                    want = strip_due.pop_front();
                    got = result_t'(m_tdata[$bits(result_t)-1:0]);
                    check_field("red", 32'(want.red), 32'(got.red));
                    check_field("green", 32'(want.green), 32'(got.green));
                    check_field("blue", 32'(want.blue), 32'(got.blue));
                    check_field("level", 32'(want.level), 32'(got.level));
                    check_field("fading", 32'(want.fading), 32'(got.fading));
                end
            end
            if (s_tvalid && s_tready)
            begin
                strip_due.push_back(strip_for_pass(s_tdata[0], s_tdata[8:1], s_tdata[9]));
            end
            pending = strip_due.size();
        end
    end

endmodule

// File: bench/tb_led_dimmer_patch_and_fade_control_unit.sv
// Testbench top for the LED dimmer control unit: clock, reset, stimulus and verdict.
module tb_led_dimmer_patch_and_fade_control_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import ldpf_pkg::*;

    localparam int TPS         = 61;
    localparam int FLOOR       = 0;
    localparam int PATCHES     = 5;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_OFF    = 250;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // button_down [0], pot_level [8:1], tick [9], zero [15:10]
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // red [7:0], green [15:8], blue [23:16], level [31:24], fading [32], zero [39:33]
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int fail_count;
    int pending_count;
    int sent_beats;
    bit send_calm;
    bit take_calm;
    bit hold_done;

    led_dimmer_patch_and_fade_control_unit #(
        .TICKS_PER_SECOND(TPS),
        .POT_FLOOR(FLOOR),
        .PATCH_COUNT(PATCHES)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    ldpf_checker #(
        .TICKS_PER_SECOND(TPS),
        .POT_FLOOR(FLOOR),
        .PATCH_COUNT(PATCHES)
    ) u_check (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .pready(pready),
        .paddr(paddr),
        .pwdata(pwdata),
        .failures(fail_count),
        .pending(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd1;
            default: return STEP_W'($urandom_range(2, 254));
        endcase
    endfunction

    task automatic send_pass(input logic btn, input logic [7:0] pot, input logic tk);
        int gap;
        gap = pick_gap(send_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, tk, pot, btn};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sent_beats++;
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending_count == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic configure(input logic [HOLD_W-1:0] h1, input logic [HOLD_W-1:0] h2,
                             input logic [HOLD_W-1:0] h3, input logic [HOLD_W-1:0] h4,
                             input logic [STEP_W-1:0] f1, input logic [STEP_W-1:0] f2,
                             input logic [STEP_W-1:0] f3, input logic [STEP_W-1:0] f4);
        drain();
        apb_write(REG_HOLD_SEC_1, APB_DATA_W'(h1));
        apb_write(REG_HOLD_SEC_2, APB_DATA_W'(h2));
        apb_write(REG_HOLD_SEC_3, APB_DATA_W'(h3));
        apb_write(REG_HOLD_SEC_4, APB_DATA_W'(h4));
        apb_write(REG_FADE_STEP_1, APB_DATA_W'(f1));
        apb_write(REG_FADE_STEP_2, APB_DATA_W'(f2));
        apb_write(REG_FADE_STEP_3, APB_DATA_W'(f3));
        apb_write(REG_FADE_STEP_4, APB_DATA_W'(f4));
    endtask

    // Mostly press, hold and release gestures with random pot and tick content.
    task automatic run_gestures(input int budget);
        int n;
        int len;
        int tick_pct;
        int r;
        n = 0;
        while (n < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                send_pass(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
                n++;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    len = $urandom_range(1, 6);
                else if (r < 90)
                    len = $urandom_range(20, 120);
                else
                    len = $urandom_range(150, 250);
                case ($urandom_range(0, 3))
                    0:       tick_pct = 0;
                    1:       tick_pct = 50;
                    default: tick_pct = 97;
                endcase
                repeat (len)
                begin
                    send_pass(1'b1, 8'($urandom_range(0, 255)), $urandom_range(0, 99) < tick_pct);
                end
                send_pass(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 3))
                begin
                    send_pass(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
                n += len + 1;
            end
        end
    endtask

    initial
    begin
        int stall;
        m_tready = 1'b0;
        take_calm = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) == 0)
                take_calm = !take_calm;
            if (!hold_done && sent_beats >= 300)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(negedge clk);
                hold_done = 1'b1;
            end
            stall = pick_gap(take_calm);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sent_beats = 0;
        send_calm = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Pot extremes and lone ticks, then short presses that walk and wrap the patches.
        send_pass(1'b0, 8'h00, 1'b0);
        send_pass(1'b0, 8'hFF, 1'b1);
        send_pass(1'b0, 8'h55, 1'b1);
        send_pass(1'b0, 8'hAA, 1'b0);
        repeat (6)
        begin
            send_pass(1'b1, 8'($urandom_range(0, 255)), 1'b0);
            send_pass(1'b0, 8'($urandom_range(0, 255)), 1'b1);
        end
        // A held button below the first threshold keeps fade mode off.
        send_pass(1'b1, 8'h80, 1'b1);
        send_pass(1'b1, 8'h01, 1'b1);
        send_pass(1'b0, 8'hFE, 1'b0);

        configure(11'd0, 11'd1, 11'd2, 11'd3, 8'd255, 8'd1, 8'd0, 8'd128);
        run_gestures(120);
        configure(11'd0, 11'd0, 11'd0, 11'd0, 8'd0, 8'd0, 8'd0, 8'd255);
        run_gestures(120);

        // One steady hold that climbs past the low thresholds while the upper ones stay out of reach.
        configure(11'd1, 11'd2, 11'd1074, 11'd2047, 8'd1, 8'd2, 8'd4, 8'd255);
        send_calm = 1'b1;
        send_pass(1'b1, 8'($urandom_range(0, 255)), 1'b0);
        repeat (130)
        begin
            send_pass(1'b1, 8'($urandom_range(0, 255)), 1'b1);
        end
        send_pass(1'b0, 8'($urandom_range(0, 255)), 1'b0);
        send_calm = 1'b0;

        repeat (4)
        begin
            configure(HOLD_W'($urandom_range(0, 4)), HOLD_W'($urandom_range(0, 4)),
                      HOLD_W'($urandom_range(0, 4)), HOLD_W'($urandom_range(0, 4)),
                      pick_step(), pick_step(), pick_step(), pick_step());
            run_gestures(120);
        end

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
